>>> hw/rtl/d2q9_pkg.sv
package d2q9_pkg;

    // cell geometry and field widths
    localparam int NDIR = 9;
    localparam int FW = 24;
    localparam int RW = 28;
    localparam int OW = 22;
    localparam int FRAC = 20;

    // beat layout
    localparam int IN_W = NDIR * FW;
    localparam int OUT_RHO_LSB = NDIR * FW;
    localparam int OUT_UX_LSB = OUT_RHO_LSB + RW;
    localparam int OUT_UY_LSB = OUT_UX_LSB + FW;
    localparam int OUT_USED = OUT_UY_LSB + FW;
    localparam int OUT_W = ((OUT_USED + 7) / 8) * 8;

    // velocity divider: quotient magnitude bits and numerator width
    localparam int QB = FW + 1;
    localparam int OV_SH = QB - FRAC;
    localparam int NUM_W = RW - 1 + FRAC;

    // equilibrium datapath widths
    localparam int CU_W = FW + 2;
    localparam int SQ_W = 2 * (FW + 1);
    localparam int BR40_W = 56;
    localparam int BR_W = 34;
    localparam int PR_W = BR_W + RW;
    localparam int MAG_W = 48;
    localparam int NIB_PER_STG = 3;
    localparam int DIV9_STG = MAG_W / (4 * NIB_PER_STG);
    localparam int DIFF_W = 44;
    localparam int DH_W = DIFF_W - FRAC;
    localparam int MH_W = DH_W + OW + 1;
    localparam int MLF_W = FRAC + OW;
    localparam int FN_W = 50;

    // pipeline depth in register stages
    localparam int NSTG = 2 + QB + 5 + DIV9_STG + 3;

    localparam int F_MAX = (1 << (FW - 1)) - 1;
    localparam int F_MIN = -(1 << (FW - 1));
    localparam int F_LIM = 1 << (FW - 1);

    localparam logic [OW-1:0] RATE_RESET = OW'(1 << FRAC);
    localparam logic signed [BR40_W-1:0] BR_ONE = BR40_W'(1) << (2 * FRAC);

    // lattice directions: rest, n, e, s, w, ne, se, sw, nw
    localparam int DIR_CX [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int DIR_CY [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    // weight scaling as a right shift of |p|: 4/9 -> 18, 1/9 -> 20, 1/36 -> 22
    localparam int WT_SHIFT [NDIR] = '{18, 20, 20, 20, 20, 22, 22, 22, 22};

    typedef struct packed {
        logic [NDIR-1:0][FW-1:0] f;
        logic [RW-1:0]           rho;
        logic [FW-1:0]           ux;
        logic [FW-1:0]           uy;
    } cell_t;

    typedef struct packed {
        logic          sx;
        logic          sy;
        logic          ovx;
        logic          ovy;
        logic          zero;
        logic [RW-1:0] d;
    } divctl_t;

    // one restoring step: compare remainder with divisor shifted by sh
    function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] r,
                                                 input logic [RW-1:0] d,
                                                 input int sh);
        logic [NUM_W+RW-1:0] dd;
        logic [NUM_W+RW-1:0] rr;
        dd = {{NUM_W{1'b0}}, d} << sh;
        rr = {{RW{1'b0}}, r};
        if (rr >= dd) begin
            return {1'b1, NUM_W'(rr - dd)};
        end
        return {1'b0, r};
    endfunction

    // one radix-16 digit of a divide by nine, returns {digit, remainder}
    function automatic logic [7:0] div9_digit(input logic [3:0] rem,
                                              input logic [3:0] nib);
        logic [7:0]  t;
        logic [13:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        t = {rem, nib};
        p = 14'(t) * 14'd57;
        q = p[12:9];
        r = t - 8'(q) * 8'd9;
        return {q, r[3:0]};
    endfunction

    // velocity from quotient magnitude, with sign, overflow and zero density
    function automatic logic [FW-1:0] vel_sat(input logic [QB-1:0] q,
                                              input logic ov,
                                              input logic neg,
                                              input logic zero);
        if (zero) begin
            return '0;
        end
        if (neg) begin
            if (ov || q > QB'(F_LIM)) begin
                return FW'(F_MIN);
            end
            return FW'(QB'(0) - q);
        end
        if (ov || q > QB'(F_MAX)) begin
            return FW'(F_MAX);
        end
        return FW'(q);
    endfunction

    function automatic logic [FW-1:0] sat_fw(input logic signed [FN_W-1:0] v);
        if (v > F_MAX) begin
            return FW'(F_MAX);
        end
        if (v < F_MIN) begin
            return FW'(F_MIN);
        end
        return v[FW-1:0];
    endfunction

endpackage

>>> hw/rtl/d2q9_bgk_collision_unit.sv
// D2Q9 BGK collision, one lattice cell per beat.
// Slave channel s_*: one beat carries the nine distributions of a cell.
// Master channel m_*: one beat carries the nine relaxed distributions,
// the density and the two velocity components of the same cell.
// cfg_wen/cfg_wdata write the relaxation rate omega (unsigned Q2.20);
// write it only while no cell is in flight.
// Throughput: one cell per cycle while the receiver does not stall the
// output. The pipeline includes the 25-stage restoring velocity divider
// and the four-stage divide-by-nine of the equilibrium.
// Reset clears all valid bits and sets omega to 1.0.
// When the receiver stalls the output register holds its beat, the
// pipeline keeps filling its empty stages and freezes only once a
// finished cell reaches the last stage; s_tready then drops.
module d2q9_bgk_collision_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [d2q9_pkg::OW-1:0]       cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // f_rest, f_north, f_east, f_south, f_west, f_northeast, f_southeast,
    // f_southwest, f_northwest (24 bits each)
    input  logic [d2q9_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_rest .. out_northwest (24 bits each), density (28),
    // velocity_x (24), velocity_y (24), zero pad
    output logic [d2q9_pkg::OUT_W-1:0]    m_tdata
);

    localparam int NDIR = d2q9_pkg::NDIR;
    localparam int FW = d2q9_pkg::FW;
    localparam int RW = d2q9_pkg::RW;
    localparam int OW = d2q9_pkg::OW;
    localparam int FRAC = d2q9_pkg::FRAC;
    localparam int QB = d2q9_pkg::QB;
    localparam int OV_SH = d2q9_pkg::OV_SH;
    localparam int NUM_W = d2q9_pkg::NUM_W;
    localparam int CU_W = d2q9_pkg::CU_W;
    localparam int SQ_W = d2q9_pkg::SQ_W;
    localparam int BR40_W = d2q9_pkg::BR40_W;
    localparam int BR_W = d2q9_pkg::BR_W;
    localparam int PR_W = d2q9_pkg::PR_W;
    localparam int MAG_W = d2q9_pkg::MAG_W;
    localparam int NPS = d2q9_pkg::NIB_PER_STG;
    localparam int D9S = d2q9_pkg::DIV9_STG;
    localparam int DIFF_W = d2q9_pkg::DIFF_W;
    localparam int DH_W = d2q9_pkg::DH_W;
    localparam int MH_W = d2q9_pkg::MH_W;
    localparam int MLF_W = d2q9_pkg::MLF_W;
    localparam int FN_W = d2q9_pkg::FN_W;
    localparam int NSTG = d2q9_pkg::NSTG;

    // control
    logic               en;
    logic [NSTG-1:0]    v_reg;
    logic               out_valid_reg;
    logic [d2q9_pkg::OUT_W-1:0] out_data_reg;
    logic [OW-1:0]      rate_reg;

    // sums
    d2q9_pkg::cell_t          s0_c_reg, s0_c_next;
    logic signed [RW-1:0]     s0_mx_reg, s0_mx_next;
    logic signed [RW-1:0]     s0_my_reg, s0_my_next;

    // magnitudes for the divider
    d2q9_pkg::cell_t          s1_c_reg;
    d2q9_pkg::divctl_t        s1_ctl_reg, s1_ctl_next;
    logic [NUM_W-1:0]         s1_nx_reg, s1_nx_next;
    logic [NUM_W-1:0]         s1_ny_reg, s1_ny_next;

    // divider stages
    d2q9_pkg::cell_t          dv_c_reg   [QB];
    d2q9_pkg::divctl_t        dv_ctl_reg [QB];
    logic [NUM_W-1:0]         dv_rx_reg  [QB];
    logic [NUM_W-1:0]         dv_ry_reg  [QB];
    logic [QB-1:0]            dv_qx_reg  [QB];
    logic [QB-1:0]            dv_qy_reg  [QB];
    logic [NUM_W-1:0]         dv_rx_in   [QB];
    logic [NUM_W-1:0]         dv_ry_in   [QB];
    logic [QB-1:0]            dv_qx_in   [QB];
    logic [QB-1:0]            dv_qy_in   [QB];
    logic [RW-1:0]            dv_d_in    [QB];
    logic [NUM_W-1:0]         dv_rx_next [QB];
    logic [NUM_W-1:0]         dv_ry_next [QB];
    logic [QB-1:0]            dv_qx_next [QB];
    logic [QB-1:0]            dv_qy_next [QB];

    // velocity
    d2q9_pkg::cell_t          vl_c_reg, vl_c_next;

    // squares
    d2q9_pkg::cell_t          sq_c_reg;
    logic signed [FW-1:0]     ux_s, uy_s;
    logic signed [FW:0]       u_sum, u_dif;
    logic signed [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_s_reg, sq_d_reg;

    // equilibrium bracket
    d2q9_pkg::cell_t          br_c_reg;
    logic signed [FW-1:0]     bux_s, buy_s;
    logic signed [BR_W-1:0]   br_reg  [NDIR];
    logic signed [BR_W-1:0]   br_next [NDIR];

    // bracket times density
    d2q9_pkg::cell_t          pr_c_reg;
    logic signed [RW-1:0]     rho_s;
    logic signed [PR_W-1:0]   pr_reg  [NDIR];
    logic signed [PR_W-1:0]   pr_next [NDIR];

    // magnitude and weight shift
    d2q9_pkg::cell_t          mg_c_reg;
    logic [MAG_W-1:0]         mg_mag_reg  [NDIR];
    logic [MAG_W-1:0]         mg_mag_next [NDIR];
    logic [NDIR-1:0]          mg_neg_reg;

    // divide by nine
    d2q9_pkg::cell_t          d9_c_reg   [D9S];
    logic [MAG_W-1:0]         d9_val_reg [D9S][NDIR];
    logic [3:0]               d9_rem_reg [D9S][NDIR];
    logic [MAG_W-1:0]         d9_quo_reg [D9S][NDIR];
    logic [NDIR-1:0]          d9_neg_reg [D9S];
    logic [MAG_W-1:0]         d9_val_in  [D9S][NDIR];
    logic [3:0]               d9_rem_in  [D9S][NDIR];
    logic [MAG_W-1:0]         d9_quo_in  [D9S][NDIR];
    logic [MAG_W-1:0]         d9_val_next[D9S][NDIR];
    logic [3:0]               d9_rem_next[D9S][NDIR];
    logic [MAG_W-1:0]         d9_quo_next[D9S][NDIR];

    // difference to equilibrium
    d2q9_pkg::cell_t          df_c_reg;
    logic signed [DIFF_W-1:0] df_reg  [NDIR];
    logic signed [DIFF_W-1:0] df_next [NDIR];

    // relaxation products
    d2q9_pkg::cell_t          ml_c_reg;
    logic signed [MH_W-1:0]   mh_reg  [NDIR];
    logic signed [MH_W-1:0]   mh_next [NDIR];
    logic [OW-1:0]            ml_reg  [NDIR];
    logic [OW-1:0]            ml_next [NDIR];

    // final sums
    d2q9_pkg::cell_t          fn_c_reg, fn_c_next;

    // stall control: freeze only when the last stage holds a cell that cannot move
    assign en = !out_valid_reg || m_tready || !v_reg[NSTG-1];
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // relaxation rate register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= d2q9_pkg::RATE_RESET;
        end else if (cfg_wen) begin
            rate_reg <= cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], s_tvalid};
        end
    end

    // density and momentum sums
    always_comb begin
        logic signed [RW-1:0] fx;
        s0_c_next = '0;
        s0_c_next.f = s_tdata;
        s0_mx_next = '0;
        s0_my_next = '0;
        for (int i = 0; i < NDIR; i++) begin
            fx = RW'(signed'(s_tdata[i*FW +: FW]));
            s0_c_next.rho = s0_c_next.rho + fx;
            if (d2q9_pkg::DIR_CX[i] == 1) begin
                s0_mx_next = s0_mx_next + fx;
            end else if (d2q9_pkg::DIR_CX[i] == -1) begin
                s0_mx_next = s0_mx_next - fx;
            end
            if (d2q9_pkg::DIR_CY[i] == 1) begin
                s0_my_next = s0_my_next + fx;
            end else if (d2q9_pkg::DIR_CY[i] == -1) begin
                s0_my_next = s0_my_next - fx;
            end
        end
    end

    // magnitudes, quotient signs and overflow checks
    always_comb begin
        logic [RW-1:0] ax;
        logic [RW-1:0] ay;
        logic [RW-1:0] ad;
        ad = s0_c_reg.rho[RW-1] ? (~s0_c_reg.rho + 1'b1) : s0_c_reg.rho;
        ax = s0_mx_reg[RW-1] ? RW'(-s0_mx_reg) : RW'(s0_mx_reg);
        ay = s0_my_reg[RW-1] ? RW'(-s0_my_reg) : RW'(s0_my_reg);
        s1_ctl_next.d = ad;
        s1_ctl_next.zero = (s0_c_reg.rho == '0);
        s1_ctl_next.sx = s0_mx_reg[RW-1] ^ s0_c_reg.rho[RW-1];
        s1_ctl_next.sy = s0_my_reg[RW-1] ^ s0_c_reg.rho[RW-1];
        s1_ctl_next.ovx = ({{OV_SH{1'b0}}, ax} >= {ad, {OV_SH{1'b0}}});
        s1_ctl_next.ovy = ({{OV_SH{1'b0}}, ay} >= {ad, {OV_SH{1'b0}}});
        s1_nx_next = {ax[NUM_W-FRAC-1:0], {FRAC{1'b0}}};
        s1_ny_next = {ay[NUM_W-FRAC-1:0], {FRAC{1'b0}}};
    end

    // divider stage inputs
    always_comb begin
        dv_rx_in[0] = s1_nx_reg;
        dv_ry_in[0] = s1_ny_reg;
        dv_qx_in[0] = '0;
        dv_qy_in[0] = '0;
        dv_d_in[0] = s1_ctl_reg.d;
        for (int k = 1; k < QB; k++) begin
            dv_rx_in[k] = dv_rx_reg[k-1];
            dv_ry_in[k] = dv_ry_reg[k-1];
            dv_qx_in[k] = dv_qx_reg[k-1];
            dv_qy_in[k] = dv_qy_reg[k-1];
            dv_d_in[k] = dv_ctl_reg[k-1].d;
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        logic [NUM_W:0] stx;
        logic [NUM_W:0] sty;
        for (int k = 0; k < QB; k++) begin
            stx = d2q9_pkg::div_step(dv_rx_in[k], dv_d_in[k], QB - 1 - k);
            sty = d2q9_pkg::div_step(dv_ry_in[k], dv_d_in[k], QB - 1 - k);
            dv_rx_next[k] = stx[NUM_W-1:0];
            dv_ry_next[k] = sty[NUM_W-1:0];
            dv_qx_next[k] = {dv_qx_in[k][QB-2:0], stx[NUM_W]};
            dv_qy_next[k] = {dv_qy_in[k][QB-2:0], sty[NUM_W]};
        end
    end

    // velocity saturation
    always_comb begin
        vl_c_next = dv_c_reg[QB-1];
        vl_c_next.ux = d2q9_pkg::vel_sat(dv_qx_reg[QB-1], dv_ctl_reg[QB-1].ovx,
                                         dv_ctl_reg[QB-1].sx, dv_ctl_reg[QB-1].zero);
        vl_c_next.uy = d2q9_pkg::vel_sat(dv_qy_reg[QB-1], dv_ctl_reg[QB-1].ovy,
                                         dv_ctl_reg[QB-1].sy, dv_ctl_reg[QB-1].zero);
    end

    // velocity squares
    assign ux_s = vl_c_reg.ux;
    assign uy_s = vl_c_reg.uy;
    assign u_sum = (FW+1)'(ux_s) + (FW+1)'(uy_s);
    assign u_dif = (FW+1)'(ux_s) - (FW+1)'(uy_s);

    // equilibrium bracket per direction, reduced to 20 fraction bits
    assign bux_s = sq_c_reg.ux;
    assign buy_s = sq_c_reg.uy;
    always_comb begin
        logic signed [CU_W-1:0]   cu;
        logic signed [SQ_W-1:0]   cu2;
        logic signed [SQ_W-1:0]   usq;
        logic signed [BR40_W-1:0] lin;
        logic signed [BR40_W-1:0] quad;
        logic signed [BR40_W-1:0] uq;
        logic signed [BR40_W-1:0] b40;
        usq = sq_x_reg + sq_y_reg;
        uq = BR40_W'(usq);
        uq = ((uq <<< 1) + uq) >>> 1;
        for (int i = 0; i < NDIR; i++) begin
            cu = '0;
            if (d2q9_pkg::DIR_CX[i] == 1) begin
                cu = cu + CU_W'(bux_s);
            end else if (d2q9_pkg::DIR_CX[i] == -1) begin
                cu = cu - CU_W'(bux_s);
            end
            if (d2q9_pkg::DIR_CY[i] == 1) begin
                cu = cu + CU_W'(buy_s);
            end else if (d2q9_pkg::DIR_CY[i] == -1) begin
                cu = cu - CU_W'(buy_s);
            end
            if (d2q9_pkg::DIR_CX[i] != 0 && d2q9_pkg::DIR_CY[i] != 0) begin
                cu2 = (d2q9_pkg::DIR_CX[i] == d2q9_pkg::DIR_CY[i]) ? sq_s_reg : sq_d_reg;
            end else if (d2q9_pkg::DIR_CX[i] != 0) begin
                cu2 = sq_x_reg;
            end else if (d2q9_pkg::DIR_CY[i] != 0) begin
                cu2 = sq_y_reg;
            end else begin
                cu2 = '0;
            end
            lin = BR40_W'(cu);
            lin = (lin + lin + lin) <<< FRAC;
            quad = BR40_W'(cu2);
            quad = ((quad <<< 3) + quad) >>> 1;
            b40 = d2q9_pkg::BR_ONE + lin + quad - uq;
            b40 = b40 >>> FRAC;
            br_next[i] = b40[BR_W-1:0];
        end
    end

    // bracket times density
    assign rho_s = br_c_reg.rho;
    always_comb begin
        for (int i = 0; i < NDIR; i++) begin
            pr_next[i] = PR_W'(br_reg[i] * rho_s);
        end
    end

    // magnitude, scaled by weight numerator and 2^-20
    always_comb begin
        logic [PR_W-1:0] ap;
        for (int i = 0; i < NDIR; i++) begin
            ap = pr_reg[i][PR_W-1] ? PR_W'(-pr_reg[i]) : PR_W'(pr_reg[i]);
            mg_mag_next[i] = MAG_W'(ap >> d2q9_pkg::WT_SHIFT[i]);
        end
    end

    // divide-by-nine stage inputs
    always_comb begin
        for (int i = 0; i < NDIR; i++) begin
            d9_val_in[0][i] = mg_mag_reg[i];
            d9_rem_in[0][i] = '0;
            d9_quo_in[0][i] = '0;
            for (int j = 1; j < D9S; j++) begin
                d9_val_in[j][i] = d9_val_reg[j-1][i];
                d9_rem_in[j][i] = d9_rem_reg[j-1][i];
                d9_quo_in[j][i] = d9_quo_reg[j-1][i];
            end
        end
    end

    // a few quotient digits per stage
    always_comb begin
        logic [MAG_W-1:0] v;
        logic [3:0]       r;
        logic [MAG_W-1:0] q;
        logic [7:0]       dg;
        for (int j = 0; j < D9S; j++) begin
            for (int i = 0; i < NDIR; i++) begin
                v = d9_val_in[j][i];
                r = d9_rem_in[j][i];
                q = d9_quo_in[j][i];
                for (int n = 0; n < NPS; n++) begin
                    dg = d2q9_pkg::div9_digit(r, v[MAG_W-1 -: 4]);
                    v = v << 4;
                    q = {q[MAG_W-5:0], dg[7:4]};
                    r = dg[3:0];
                end
                d9_val_next[j][i] = v;
                d9_rem_next[j][i] = r;
                d9_quo_next[j][i] = q;
            end
        end
    end

    // signed equilibrium minus distribution
    always_comb begin
        logic signed [DIFF_W-1:0] qe;
        logic signed [DIFF_W-1:0] feq;
        for (int i = 0; i < NDIR; i++) begin
            qe = DIFF_W'(d9_quo_reg[D9S-1][i]);
            feq = d9_neg_reg[D9S-1][i] ? -qe : qe;
            df_next[i] = feq - DIFF_W'(signed'(d9_c_reg[D9S-1].f[i]));
        end
    end

    // difference times omega, split at the binary point
    always_comb begin
        logic signed [DH_W-1:0]  dh;
        logic [FRAC-1:0]         dl;
        logic signed [OW:0]      om_s;
        logic [MLF_W-1:0]        lo;
        om_s = {1'b0, rate_reg};
        for (int i = 0; i < NDIR; i++) begin
            dh = df_reg[i][DIFF_W-1:FRAC];
            dl = df_reg[i][FRAC-1:0];
            mh_next[i] = MH_W'(dh * om_s);
            lo = MLF_W'(dl) * MLF_W'(rate_reg);
            ml_next[i] = lo[MLF_W-1:FRAC];
        end
    end

    // relaxed values with saturation
    always_comb begin
        logic signed [FN_W-1:0] sum;
        fn_c_next = ml_c_reg;
        for (int i = 0; i < NDIR; i++) begin
            sum = FN_W'(mh_reg[i]) + FN_W'(signed'({1'b0, ml_reg[i]}))
                + FN_W'(signed'(ml_c_reg.f[i]));
            fn_c_next.f[i] = d2q9_pkg::sat_fw(sum);
        end
    end

    // pipeline payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_c_reg <= s0_c_next;
            s0_mx_reg <= s0_mx_next;
            s0_my_reg <= s0_my_next;

            s1_c_reg <= s0_c_reg;
            s1_ctl_reg <= s1_ctl_next;
            s1_nx_reg <= s1_nx_next;
            s1_ny_reg <= s1_ny_next;

            dv_c_reg[0] <= s1_c_reg;
            dv_ctl_reg[0] <= s1_ctl_reg;
            for (int k = 1; k < QB; k++) begin
                dv_c_reg[k] <= dv_c_reg[k-1];
                dv_ctl_reg[k] <= dv_ctl_reg[k-1];
            end
            for (int k = 0; k < QB; k++) begin
                dv_rx_reg[k] <= dv_rx_next[k];
                dv_ry_reg[k] <= dv_ry_next[k];
                dv_qx_reg[k] <= dv_qx_next[k];
                dv_qy_reg[k] <= dv_qy_next[k];
            end

            vl_c_reg <= vl_c_next;

            sq_c_reg <= vl_c_reg;
            sq_x_reg <= SQ_W'(ux_s * ux_s);
            sq_y_reg <= SQ_W'(uy_s * uy_s);
            sq_s_reg <= SQ_W'(u_sum * u_sum);
            sq_d_reg <= SQ_W'(u_dif * u_dif);

            br_c_reg <= sq_c_reg;
            pr_c_reg <= br_c_reg;
            mg_c_reg <= pr_c_reg;
            for (int i = 0; i < NDIR; i++) begin
                br_reg[i] <= br_next[i];
                pr_reg[i] <= pr_next[i];
                mg_mag_reg[i] <= mg_mag_next[i];
                mg_neg_reg[i] <= pr_reg[i][PR_W-1];
            end

            d9_c_reg[0] <= mg_c_reg;
            d9_neg_reg[0] <= mg_neg_reg;
            for (int j = 1; j < D9S; j++) begin
                d9_c_reg[j] <= d9_c_reg[j-1];
                d9_neg_reg[j] <= d9_neg_reg[j-1];
            end
            for (int j = 0; j < D9S; j++) begin
                for (int i = 0; i < NDIR; i++) begin
                    d9_val_reg[j][i] <= d9_val_next[j][i];
                    d9_rem_reg[j][i] <= d9_rem_next[j][i];
                    d9_quo_reg[j][i] <= d9_quo_next[j][i];
                end
            end

            df_c_reg <= d9_c_reg[D9S-1];
            ml_c_reg <= df_c_reg;
            for (int i = 0; i < NDIR; i++) begin
                df_reg[i] <= df_next[i];
                mh_reg[i] <= mh_next[i];
                ml_reg[i] <= ml_next[i];
            end

            fn_c_reg <= fn_c_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= v_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= {{(d2q9_pkg::OUT_W - d2q9_pkg::OUT_USED){1'b0}},
                             fn_c_reg.uy, fn_c_reg.ux, fn_c_reg.rho, fn_c_reg.f};
        end
    end

    // accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // a frozen pipeline keeps its valid bits
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    // zero density gives zero velocity
    a_zero_density: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[d2q9_pkg::OUT_RHO_LSB +: RW] == '0)
        |-> (m_tdata[d2q9_pkg::OUT_UX_LSB +: 2*FW] == '0))
        else $error("nonzero velocity with zero density");

    // stalled output register only frees the pipeline when its stage is empty
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && v_reg[NSTG-1]))
        else $error("input stalled without a blocked result");

endmodule
